// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl of the sliding window max/min block
// no dependencies; the checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SWMM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true at a clock edge out of reset
`define SWMM_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SWMM_ASSERT(label, clk, rst_n, prop, msg)
`define SWMM_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- hw/rtl/swmm_pkg.sv -----
// shared types and constants of the sliding window max/min block
// no dependencies
`default_nettype none

package swmm_pkg;

    localparam int DATA_W         = 32;
    localparam int WLEN_W         = 11;
    localparam int WINDOW_MAX_DEF = 1024;

    // per-cycle command broadcast to every cell of the candidate chain
    typedef struct packed {
        logic accept;
        logic shift;
        logic purge;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swmm_cell.sv -----
// one cell of the candidate chain: holds one max candidate and its age
// depends on swmm_pkg
`default_nettype none

module swmm_cell import swmm_pkg::*;
#(
    parameter int AGE_W = 11
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic signed [DATA_W-1:0] sample,
    input  wire logic                     left_keep,
    input  wire logic signed [DATA_W-1:0] r_value,
    input  wire logic        [AGE_W-1:0]  r_age,
    input  wire logic                     r_valid,
    output logic signed      [DATA_W-1:0] value,
    output logic             [AGE_W-1:0]  age,
    output logic                          valid,
    output logic                          keep,
    output logic signed      [DATA_W-1:0] upd_value
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic        [AGE_W-1:0]  age_reg;
    logic        [AGE_W-1:0]  age_next;
    logic                     valid_reg;
    logic                     valid_next;

    logic signed [DATA_W-1:0] src_value;
    logic        [AGE_W-1:0]  src_age;
    logic                     src_valid;

    // when the oldest candidate leaves, everything moves one cell toward the front
    assign src_value = ctrl.shift ? r_value : value_reg;
    assign src_age   = ctrl.shift ? r_age   : age_reg;
    assign src_valid = ctrl.shift ? r_valid : valid_reg;

    // ties survive: only a strictly larger sample removes a candidate
    assign keep      = src_valid && (src_value >= sample);
    assign upd_value = keep ? src_value : sample;

    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (ctrl.accept)
        begin
            value_next = upd_value;
            age_next   = keep ? (src_age + AGE_W'(1)) : '0;
            // first cell past the survivors takes the new sample
            valid_next = ctrl.clear ? 1'b0 : (keep || left_keep);
        end
        else if (ctrl.purge)
        begin
            value_next = r_value;
            age_next   = r_age;
            valid_next = r_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign value = value_reg;
    assign age   = age_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/swmm_min_stage.sv -----
// second stage and output register: running minimum of full-window maxima
// depends on swmm_pkg
`default_nettype none

module swmm_min_stage import swmm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire logic signed [DATA_W-1:0] front,
    input  wire logic                     full,
    input  wire logic                     last,
    output logic                          mid_ready,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed      [DATA_W-1:0] window_max,
    output logic                          window_full,
    output logic signed      [DATA_W-1:0] min_of_maxima,
    output logic                          min_valid,
    output logic                          end_of_array
);

    logic                     mid_valid_reg;
    logic                     mid_valid_next;
    logic signed [DATA_W-1:0] front_reg;
    logic                     full_reg;
    logic                     last_reg;

    logic signed [DATA_W-1:0] rmin_reg;
    logic signed [DATA_W-1:0] rmin_next;
    logic                     rmin_valid_reg;
    logic                     rmin_valid_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] max_reg;
    logic                     full_out_reg;
    logic signed [DATA_W-1:0] min_out_reg;
    logic                     min_valid_out_reg;
    logic                     end_reg;

    logic                     out_free;
    logic                     out_load;
    logic signed [DATA_W-1:0] new_min;
    logic                     new_min_valid;

    assign out_free  = !out_valid_reg || !out_stall;
    assign mid_ready = !mid_valid_reg || out_free;
    assign out_load  = out_free && mid_valid_reg;

    always_comb
    begin
        new_min       = rmin_reg;
        new_min_valid = rmin_valid_reg;
        if (full_reg && (!rmin_valid_reg || (front_reg < rmin_reg)))
        begin
            new_min       = front_reg;
            new_min_valid = 1'b1;
        end
    end

    always_comb
    begin
        mid_valid_next  = mid_ready ? load : mid_valid_reg;
        out_valid_next  = out_free ? mid_valid_reg : out_valid_reg;
        rmin_next       = rmin_reg;
        rmin_valid_next = rmin_valid_reg;
        if (out_load)
        begin
            // end of array starts the next one from scratch
            rmin_next       = last_reg ? '0 : new_min;
            rmin_valid_next = last_reg ? 1'b0 : new_min_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            rmin_reg       <= '0;
            rmin_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg  <= mid_valid_next;
            out_valid_reg  <= out_valid_next;
            rmin_reg       <= rmin_next;
            rmin_valid_reg <= rmin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_ready && load)
        begin
            front_reg <= front;
            full_reg  <= full;
            last_reg  <= last;
        end
        if (out_load)
        begin
            max_reg           <= front_reg;
            full_out_reg      <= full_reg;
            min_out_reg       <= new_min_valid ? new_min : '0;
            min_valid_out_reg <= new_min_valid;
            end_reg           <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_max    = max_reg;
    assign window_full   = full_out_reg;
    assign min_of_maxima = min_out_reg;
    assign min_valid     = min_valid_out_reg;
    assign end_of_array  = end_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_max_min.sv -----
// Sliding window maximum with a running minimum of the full-window maxima.
// Takes one sample per clock while in_stall is low and gives one result per
// sample, through the middle register and then the output register after it is
// accepted. The candidate queue is a chain of WINDOW_MAX cells, each with one
// 32-bit compare against the new sample, so the steady rate is one sample per
// cycle while out_stall stays low. After window_len is lowered, each candidate
// beyond the first that the next sample would push out of the shorter window is
// drained from the front of the chain while that sample waits. window_len of 0
// acts as 1, values above WINDOW_MAX act as WINDOW_MAX.
// depends on swmm_pkg, swmm_cell, swmm_min_stage and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sliding_window_max_min import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic        [WLEN_W-1:0] window_len,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [DATA_W-1:0] sample,
    input  wire logic                     last_sample,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed      [DATA_W-1:0] window_max,
    output logic                          window_full,
    output logic signed      [DATA_W-1:0] min_of_maxima,
    output logic                          min_valid,
    output logic                          end_of_array
);

    localparam int AGE_W = $clog2(WINDOW_MAX + 1);

    logic        [WLEN_W-1:0] wlen_reg;
    logic        [31:0]       w_wide;
    logic        [AGE_W-1:0]  w_eff;

    logic        [AGE_W-1:0]  seen_count_reg;
    logic        [AGE_W-1:0]  seen_count_next;
    logic        [AGE_W-1:0]  seen_clamp;
    logic                     full;

    logic                     accept;
    logic                     mid_ready;
    logic                     purge_needed;
    logic                     front_drop;
    cell_ctrl_t               ctrl;

    logic signed [DATA_W-1:0] value_q   [WINDOW_MAX];
    logic        [AGE_W-1:0]  age_q     [WINDOW_MAX];
    logic        [WINDOW_MAX-1:0] valid_q;
    logic        [WINDOW_MAX-1:0] keep;
    logic signed [DATA_W-1:0] upd_value [WINDOW_MAX];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            wlen_reg <= window_len;
        end
    end

    always_comb
    begin
        w_wide = {{(32 - WLEN_W){1'b0}}, wlen_reg};
        if (w_wide == 32'd0)
        begin
            w_wide = 32'd1;
        end
        if (w_wide > 32'(WINDOW_MAX))
        begin
            w_wide = 32'(WINDOW_MAX);
        end
    end

    assign w_eff = w_wide[AGE_W-1:0];

    // handshake and chain control
    // the second cell must be young enough that one step drops at most the front
    assign purge_needed = valid_q[1] &&
                          (({1'b0, age_q[1]} + (AGE_W + 1)'(1)) >= {1'b0, w_eff});
    assign front_drop   = valid_q[0] &&
                          (({1'b0, age_q[0]} + (AGE_W + 1)'(1)) >= {1'b0, w_eff});

    assign in_stall = !mid_ready || purge_needed;
    assign accept   = in_valid && !in_stall;

    // drain only for a waiting sample, so a later wider window keeps its candidates
    always_comb
    begin
        ctrl.accept = accept;
        ctrl.shift  = front_drop;
        ctrl.purge  = purge_needed && in_valid && !accept;
        ctrl.clear  = accept && last_sample;
    end

    // samples seen in this array, saturating at the window length
    always_comb
    begin
        seen_clamp      = (seen_count_reg > w_eff) ? w_eff : seen_count_reg;
        seen_count_next = (seen_clamp < w_eff) ? (seen_clamp + AGE_W'(1)) : seen_clamp;
    end

    assign full = (seen_count_next >= w_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_count_reg <= '0;
        end
        else if (accept)
        begin
            seen_count_reg <= last_sample ? '0 : seen_count_next;
        end
    end

    // candidate chain, oldest candidate in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] r_value;
            logic        [AGE_W-1:0]  r_age;
            logic                     r_valid;
            logic                     left_keep;

            if (gi == WINDOW_MAX - 1)
            begin : g_tail
                assign r_value = '0;
                assign r_age   = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_body
                assign r_value = value_q[gi+1];
                assign r_age   = age_q[gi+1];
                assign r_valid = valid_q[gi+1];
            end

            if (gi == 0)
            begin : g_head
                assign left_keep = 1'b1;
            end
            else
            begin : g_rest
                assign left_keep = keep[gi-1];
            end

            swmm_cell #(
                .AGE_W (AGE_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .sample    (sample),
                .left_keep (left_keep),
                .r_value   (r_value),
                .r_age     (r_age),
                .r_valid   (r_valid),
                .value     (value_q[gi]),
                .age       (age_q[gi]),
                .valid     (valid_q[gi]),
                .keep      (keep[gi]),
                .upd_value (upd_value[gi])
            );
        end
    endgenerate

    swmm_min_stage u_min_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .front         (upd_value[0]),
        .full          (full),
        .last          (last_sample),
        .mid_ready     (mid_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .window_max    (window_max),
        .window_full   (window_full),
        .min_of_maxima (min_of_maxima),
        .min_valid     (min_valid),
        .end_of_array  (end_of_array)
    );

    `SWMM_ASSERT(a_front_after_beat, clk, rst_n, (accept && !last_sample) |=> valid_q[0], "front cell empty after a sample beat")
    `SWMM_ASSERT(a_clear_on_last, clk, rst_n, (accept && last_sample) |=> (!valid_q[0] && (seen_count_reg == '0)), "state not cleared after last sample")
    `SWMM_ASSERT(a_seen_bounded, clk, rst_n, accept |=> (seen_count_reg <= $past(w_eff)), "seen count beyond window length")
    `SWMM_ASSERT(a_valid_prefix, clk, rst_n, valid_q[1] |-> valid_q[0], "candidate chain has a hole at the front")

endmodule

`default_nettype wire
